FILE: hw/rtl/skct_pkg.sv
// Shared types and constants for the sorted key and count table.
`default_nettype none

package skct_pkg;

  // Field widths of the stream words.
  localparam int KEY_W  = 32;
  localparam int CNT_W  = 32;
  localparam int MODE_W = 2;
  localparam int STAT_W = 3;
  localparam int POS_W  = 8;
  localparam int IN_W   = 72;
  localparam int OUT_W  = 56;

  // Request kinds.
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUB    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP     = 3'd2;
  localparam logic [STAT_W-1:0] ST_MISSING = 3'd3;
  localparam logic [STAT_W-1:0] ST_SHORT   = 3'd4;
  localparam logic [STAT_W-1:0] ST_SAT     = 3'd5;

  // Result word, last field in the lowest bits.
  typedef struct packed {
    logic [POS_W-1:0]  occupancy;
    logic [CNT_W-1:0]  count_value;
    logic [POS_W-1:0]  position;
    logic              found;
    logic [STAT_W-1:0] status;
  } result_t;

  // Request word, last field in the lowest bits.
  typedef struct packed {
    logic [CNT_W-1:0]  amount;
    logic [KEY_W-1:0]  key;
    logic [MODE_W-1:0] mode;
  } request_t;

endpackage

`default_nettype wire

FILE: hw/rtl/skct_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module skct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_key_count_table_top.sv
// Top level of the sorted key and count table with its request sequencer.
//
// Usage: requests arrive as words on the s_axis channel (mode, key, amount);
// each request yields exactly one result word on the m_axis channel
// (status, found, position, count_value, occupancy). Entries are kept in
// ascending key order in two RAMs, one for keys and one for counts.
// One request is worked on at a time; s_axis_tready is high only while the
// sequencer is idle. Every request first runs a binary search through the
// key RAM: each probe is a read issued in S_PROBE and a compare in S_CMP;
// there are at most clog2(TABLE_DEPTH)+1 probes, and a miss ends the search
// in S_PROBE. An execute state follows, and a load of the output ends it.
// A successful insert moves every entry from the insertion point up by one,
// one entry per cycle, then writes the new entry. A new word is taken only
// after the result of the last one is loaded into the output register.
// A result waits in an output register while the receiver stalls; the next
// request is accepted meanwhile, but its result and the input then hold
// until the register is free. Reset empties the table at once.
`default_nettype none

module sorted_key_count_table_top #(
  parameter int TABLE_DEPTH = 128
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Fields from bit 0: mode[1:0], key[33:2], amount[65:34], zero fill.
  input  wire logic [skct_pkg::IN_W-1:0]  s_axis_tdata,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // Fields from bit 0: status[2:0], found[3], position[11:4],
  // count_value[43:12], occupancy[51:44], zero fill.
  output logic [skct_pkg::OUT_W-1:0]  m_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready
);

  import skct_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int IDX_W = $clog2(TABLE_DEPTH + 1);

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_PLACE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  request_t req_in;

  logic [2:0]        state, state_next;
  logic [MODE_W-1:0] mode_q, mode_next;
  logic [KEY_W-1:0]  key_q, key_next;
  logic [CNT_W-1:0]  amt_q, amt_next;
  logic [IDX_W-1:0]  lo, lo_next;
  logic [IDX_W-1:0]  hi, hi_next;
  logic [IDX_W-1:0]  mid_q, mid_next;
  logic              found_q, found_next;
  logic [IDX_W-1:0]  pos_q, pos_next;
  logic [CNT_W-1:0]  cnt_q, cnt_next;
  logic [IDX_W-1:0]  total, total_next;
  logic [IDX_W-1:0]  j, j_next;
  logic [STAT_W-1:0] status_q, status_next;
  logic [CNT_W-1:0]  res_cnt, res_cnt_next;
  result_t           out_q, out_next;
  logic              out_valid, out_valid_next;

  logic [IDX_W:0]    lo_hi_sum;
  logic [IDX_W-1:0]  mid;
  logic [IDX_W-1:0]  jm1, jm2, total_m1;
  logic [CNT_W:0]    add_sum;
  logic [IDX_W+7:0]  pos_ext, total_ext;

  // RAM port signals.
  logic              key_we, cnt_we;
  logic [AW-1:0]     waddr, raddr;
  logic [KEY_W-1:0]  key_wdata, key_rdata;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;

  assign req_in    = request_t'(s_axis_tdata[$bits(request_t)-1:0]);
  assign lo_hi_sum = {1'b0, lo} + {1'b0, hi};
  assign mid       = lo_hi_sum[IDX_W:1];
  assign jm1       = j - IDX_W'(1);
  assign jm2       = j - IDX_W'(2);
  assign total_m1  = total - IDX_W'(1);
  assign add_sum   = {1'b0, cnt_q} + {1'b0, amt_q};
  assign pos_ext   = {8'b0, pos_q};
  assign total_ext = {8'b0, total};

  skct_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  skct_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_DEPTH)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (waddr),
    .wdata (cnt_wdata),
    .raddr (raddr),
    .rdata (cnt_rdata)
  );

  // Sequencer: search, execute, move entries, report.
  always_comb begin
    state_next     = state;
    mode_next      = mode_q;
    key_next       = key_q;
    amt_next       = amt_q;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid_q;
    found_next     = found_q;
    pos_next       = pos_q;
    cnt_next       = cnt_q;
    total_next     = total;
    j_next         = j;
    status_next    = status_q;
    res_cnt_next   = res_cnt;
    out_next       = out_q;
    out_valid_next = out_valid && !m_axis_tready;
    s_axis_tready  = 1'b0;
    key_we         = 1'b0;
    cnt_we         = 1'b0;
    waddr          = pos_q[AW-1:0];
    raddr          = mid[AW-1:0];
    key_wdata      = key_rdata;
    cnt_wdata      = cnt_rdata;

    unique case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          mode_next  = req_in.mode;
          key_next   = req_in.key;
          amt_next   = req_in.amount;
          lo_next    = '0;
          hi_next    = total;
          state_next = S_PROBE;
        end
      end

      // Issue a probe read at the midpoint, or end the search.
      S_PROBE: begin
        if (lo < hi) begin
          mid_next   = mid;
          state_next = S_CMP;
        end else begin
          found_next = 1'b0;
          pos_next   = lo;
          cnt_next   = '0;
          state_next = S_EXEC;
        end
      end

      // Compare the probed key and narrow the range.
      S_CMP: begin
        if (key_rdata == key_q) begin
          found_next = 1'b1;
          pos_next   = mid_q;
          cnt_next   = cnt_rdata;
          state_next = S_EXEC;
        end else begin
          if (key_rdata < key_q) begin
            lo_next = mid_q + IDX_W'(1);
          end else begin
            hi_next = mid_q;
          end
          state_next = S_PROBE;
        end
      end

      // Carry out the request on the located entry.
      S_EXEC: begin
        state_next = S_DONE;
        unique case (mode_q)
          MODE_INSERT: begin
            if (total >= IDX_W'(TABLE_DEPTH)) begin
              status_next  = ST_FULL;
              res_cnt_next = found_q ? cnt_q : '0;
            end else if (found_q) begin
              status_next  = ST_DUP;
              res_cnt_next = cnt_q;
            end else begin
              status_next  = ST_OK;
              res_cnt_next = amt_q;
              if (total > pos_q) begin
                raddr      = total_m1[AW-1:0];
                j_next     = total;
                state_next = S_SHIFT;
              end else begin
                state_next = S_PLACE;
              end
            end
          end
          MODE_ADD: begin
            if (!found_q) begin
              status_next  = ST_MISSING;
              res_cnt_next = '0;
            end else begin
              cnt_we = 1'b1;
              if (add_sum[CNT_W]) begin
                status_next = ST_SAT;
                cnt_wdata   = '1;
              end else begin
                status_next = ST_OK;
                cnt_wdata   = add_sum[CNT_W-1:0];
              end
              res_cnt_next = cnt_wdata;
            end
          end
          MODE_SUB: begin
            if (!found_q) begin
              status_next  = ST_MISSING;
              res_cnt_next = '0;
            end else if (cnt_q < amt_q) begin
              status_next  = ST_SHORT;
              res_cnt_next = cnt_q;
            end else begin
              status_next  = ST_OK;
              cnt_we       = 1'b1;
              cnt_wdata    = cnt_q - amt_q;
              res_cnt_next = cnt_wdata;
            end
          end
          MODE_LOOKUP: begin
            status_next  = found_q ? ST_OK : ST_MISSING;
            res_cnt_next = found_q ? cnt_q : '0;
          end
          default: begin
            status_next = ST_OK;
          end
        endcase
      end

      // Move one entry up per cycle, from the top down to the insertion point.
      S_SHIFT: begin
        key_we = 1'b1;
        cnt_we = 1'b1;
        waddr  = j[AW-1:0];
        if (jm1 > pos_q) begin
          raddr  = jm2[AW-1:0];
          j_next = jm1;
        end else begin
          state_next = S_PLACE;
        end
      end

      // Write the new entry into the opened slot.
      S_PLACE: begin
        key_we     = 1'b1;
        cnt_we     = 1'b1;
        key_wdata  = key_q;
        cnt_wdata  = amt_q;
        total_next = total + IDX_W'(1);
        state_next = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_next.status      = status_q;
          out_next.found       = found_q;
          out_next.position    = pos_ext[7:0];
          out_next.count_value = res_cnt;
          out_next.occupancy   = total_ext[7:0];
          out_valid_next       = 1'b1;
          state_next           = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      total     <= total_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mode_q   <= mode_next;
    key_q    <= key_next;
    amt_q    <= amt_next;
    lo       <= lo_next;
    hi       <= hi_next;
    mid_q    <= mid_next;
    found_q  <= found_next;
    pos_q    <= pos_next;
    cnt_q    <= cnt_next;
    j        <= j_next;
    status_q <= status_next;
    res_cnt  <= res_cnt_next;
    out_q    <= out_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_W - $bits(result_t)){1'b0}}, out_q};

  // The table never holds more entries than it has room for.
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= IDX_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // The entry count only grows, and by at most one per cycle.
  a_total_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (total == $past(total) || total == $past(total) + IDX_W'(1)))
    else $error("entry count changed unexpectedly");

  // After a request is taken, no other is taken in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while busy");

  // The search range stays ordered while probing.
  a_range_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE || state == S_CMP) |-> lo <= hi)
    else $error("search range inverted");

endmodule

`default_nettype wire
